/* src/complex_quadratic_roots_defines.svh */
// Assertion macros shared by the RTL of the quadratic root solver.
`ifndef COMPLEX_QUADRATIC_ROOTS_DEFINES_SVH
`define COMPLEX_QUADRATIC_ROOTS_DEFINES_SVH

// Two expressions must agree at every clock edge out of reset.
`define CQR_ASSERT_EQ(lbl, lhs, rhs) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) == (rhs)) \
        else $error("cqr: values out of lockstep");

// Condition pre implies post in the same cycle.
`define CQR_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("cqr: implication violated");

`endif

/* src/cqr_pkg.sv */
// Shared types for the quadratic root solver pipeline.
package cqr_pkg;

    // Pipeline control handed to each sub-pipeline.
    typedef struct packed {
        logic ce;     // advance all stages
        logic valid;  // item present at the input of the sub-pipeline
    } pipe_ctl_t;

endpackage

/* src/cqr_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module cqr_sqrt import cqr_pkg::*; #(
    parameter int IN_W  = 104,
    parameter int TAG_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pipe_ctl_t           in_ctl,
    input  logic [IN_W-1:0]     in_rad,
    input  logic [TAG_W-1:0]    in_tag,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [TAG_W-1:0]    out_tag
);
    localparam int RW = IN_W / 2;

    logic [IN_W-1:0]  rad_reg  [0:RW];
    logic [RW:0]      rem_reg  [0:RW];
    logic [RW-1:0]    root_reg [0:RW];
    logic [TAG_W-1:0] tag_reg  [0:RW];
    logic             vld_reg  [0:RW];

    always_ff @(posedge aclk) begin
        if (in_ctl.ce) begin
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            tag_reg[0]  <= in_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (in_ctl.ce) begin
            vld_reg[0] <= in_ctl.valid;
        end
    end

    for (genvar k = 1; k <= RW; k++) begin : g_step
        logic [RW+2:0] rem_sh;
        logic [RW+2:0] trial;
        logic [RW+2:0] diff;
        logic          take;
        logic [RW:0]   rem_next;

        assign rem_sh   = {rem_reg[k-1], rad_reg[k-1][IN_W-1 -: 2]};
        assign trial    = {1'b0, root_reg[k-1], 2'b01};
        assign take     = (rem_sh >= trial);
        assign diff     = rem_sh - trial;
        assign rem_next = take ? diff[RW:0] : rem_sh[RW:0];

        always_ff @(posedge aclk) begin
            if (in_ctl.ce) begin
                rad_reg[k]  <= rad_reg[k-1] << 2;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= {root_reg[k-1][RW-2:0], take};
                tag_reg[k]  <= tag_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (in_ctl.ce) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[RW];
    assign out_root  = root_reg[RW];
    assign out_tag   = tag_reg[RW];

endmodule

/* src/cqr_div.sv */
// Pipelined restoring unsigned divider, one quotient bit per stage.
module cqr_div import cqr_pkg::*; #(
    parameter int NUM_W = 83,
    parameter int DEN_W = 64,
    parameter int TAG_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pipe_ctl_t         in_ctl,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo,
    output logic [TAG_W-1:0]  out_tag
);
    // nq holds the unshifted numerator bits above and quotient bits below
    logic [NUM_W-1:0] nq_reg  [0:NUM_W];
    logic [DEN_W-1:0] rem_reg [0:NUM_W];
    logic [DEN_W-1:0] den_reg [0:NUM_W];
    logic [TAG_W-1:0] tag_reg [0:NUM_W];
    logic             vld_reg [0:NUM_W];

    always_ff @(posedge aclk) begin
        if (in_ctl.ce) begin
            nq_reg[0]  <= in_num;
            rem_reg[0] <= '0;
            den_reg[0] <= in_den;
            tag_reg[0] <= in_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (in_ctl.ce) begin
            vld_reg[0] <= in_ctl.valid;
        end
    end

    for (genvar k = 1; k <= NUM_W; k++) begin : g_step
        logic [DEN_W:0]   rem_sh;
        logic [DEN_W:0]   diff;
        logic             take;
        logic [DEN_W-1:0] rem_next;

        assign rem_sh   = {rem_reg[k-1], nq_reg[k-1][NUM_W-1]};
        assign take     = (rem_sh >= {1'b0, den_reg[k-1]});
        assign diff     = rem_sh - {1'b0, den_reg[k-1]};
        assign rem_next = take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

        always_ff @(posedge aclk) begin
            if (in_ctl.ce) begin
                nq_reg[k]  <= {nq_reg[k-1][NUM_W-2:0], take};
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (in_ctl.ce) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign out_quo   = nq_reg[NUM_W];
    assign out_tag   = tag_reg[NUM_W];

endmodule

/* src/complex_quadratic_roots.sv */
// Top level of the complex-coefficient quadratic root solver.
// Solves a*x^2 + b*x + c = 0 for complex a, b, c in signed fixed point (W bits,
// F fraction bits, Q16.16 by default) and returns both roots in one item, the
// root with the larger imaginary part first (minus root first on a tie). The
// block is one long pipeline that accepts an item every cycle while the output
// is not stalled; it is made of the square root of |d|^2 (2W-F+5 stages), the
// square root of the halves (W+3 stages) and the final complex division
// (2W+F+4 stages, one quotient bit per stage), plus nine arithmetic and output
// stages. A stall on the result side freezes the whole pipeline;
// nothing is lost or repeated. lead_zero flags a zero leading coefficient
// (roots reported as zero); saturated flags a root component clipped to the
// W-bit range.
`include "complex_quadratic_roots_defines.svh"

module complex_quadratic_roots import cqr_pkg::*; #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // coef_a_re, coef_a_im, coef_b_re, coef_b_im, coef_c_re, coef_c_im
    input  logic [((6*W+7)/8)*8-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // first_re, first_im, second_re, second_im
    output logic [((4*W+7)/8)*8-1:0]    m_tdata,
    // lead_zero, saturated
    output logic [1:0]                  m_tuser
);
    localparam int OUT_TD = ((4*W+7)/8)*8;
    localparam int DW     = 2*W - F + 4;    // discriminant parts
    localparam int HB     = (DW + 1) / 2;   // low half for split squaring
    localparam int HW     = DW - HB;
    localparam int MW     = 2 * DW;         // |d|^2
    localparam int S2IN   = DW + F;         // half << F
    localparam int SW     = S2IN / 2;       // root of d parts
    localparam int XW     = W + 3;          // -b +/- s
    localparam int PW     = XW + W;
    localparam int NW     = PW + 1;         // numerators
    localparam int QN     = NW + F - 1;     // scaled numerator magnitude
    localparam int DENW   = 2 * W;          // |a|^2
    localparam logic [QN-1:0] LIM_NEG = QN'(1) << (W - 1);
    localparam logic [QN-1:0] LIM_POS = LIM_NEG - QN'(1);

    typedef struct packed {
        logic                   lz;
        logic [DENW-1:0]        den;
        logic signed [W-1:0]    bi;
        logic signed [W-1:0]    br;
        logic signed [W-1:0]    ai;
        logic signed [W-1:0]    ar;
        logic signed [DW-1:0]   di;
        logic signed [DW-1:0]   dr;
    } sb1_t;

    typedef struct packed {
        logic                   lz;
        logic [DENW-1:0]        den;
        logic signed [W-1:0]    bi;
        logic signed [W-1:0]    br;
        logic signed [W-1:0]    ai;
        logic signed [W-1:0]    ar;
    } sb2_t;

    typedef struct packed {
        logic                   lz;
        logic [DENW-1:0]        den;
        logic signed [W-1:0]    ai;
        logic signed [W-1:0]    ar;
    } sb3_t;

    // Saturate a quotient magnitude to the signed W-bit range: {sat, value}.
    function automatic logic [W:0] clip_q(input logic [QN-1:0] q, input logic neg);
        logic [QN-1:0] lim;
        logic          over;
        logic [W-1:0]  m;
        lim  = neg ? LIM_NEG : LIM_POS;
        over = (q > lim);
        m    = over ? lim[W-1:0] : q[W-1:0];
        return {over, neg ? (-m) : m};
    endfunction

    // Rebuild a square from its split partial products.
    function automatic logic signed [MW+1:0] sq_join(
        input logic signed [2*HW-1:0] hh,
        input logic signed [DW:0]     hl,
        input logic signed [2*HB+1:0] ll
    );
        return ((MW+2)'(hh) <<< (2*HB)) + ((MW+2)'(hl) <<< (HB+1)) + (MW+2)'(ll);
    endfunction

    // Whole pipeline advances unless the output register holds an untaken item.
    logic      ce;
    logic      m_tvalid_reg;
    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    // ---------------- stage 1: coefficient products ----------------
    logic signed [W-1:0] ar_in, ai_in, br_in, bi_in, cr_in, ci_in;
    assign ar_in = s_tdata[0*W +: W];
    assign ai_in = s_tdata[1*W +: W];
    assign br_in = s_tdata[2*W +: W];
    assign bi_in = s_tdata[3*W +: W];
    assign cr_in = s_tdata[4*W +: W];
    assign ci_in = s_tdata[5*W +: W];

    logic signed [2*W-1:0] p_brbr_reg, p_bibi_reg, p_brbi_reg, p_arcr_reg, p_aici_reg;
    logic signed [2*W-1:0] p_arci_reg, p_aicr_reg, p_arar_reg, p_aiai_reg;
    logic signed [W-1:0]   ar_s1_reg, ai_s1_reg, br_s1_reg, bi_s1_reg;
    logic                  lz_s1_reg, v1_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_brbr_reg <= br_in * br_in;
            p_bibi_reg <= bi_in * bi_in;
            p_brbi_reg <= br_in * bi_in;
            p_arcr_reg <= ar_in * cr_in;
            p_aici_reg <= ai_in * ci_in;
            p_arci_reg <= ar_in * ci_in;
            p_aicr_reg <= ai_in * cr_in;
            p_arar_reg <= ar_in * ar_in;
            p_aiai_reg <= ai_in * ai_in;
            ar_s1_reg  <= ar_in;
            ai_s1_reg  <= ai_in;
            br_s1_reg  <= br_in;
            bi_s1_reg  <= bi_in;
            lz_s1_reg  <= (ar_in == '0) && (ai_in == '0);
        end
    end

    // ---------------- stage 2: discriminant d and |a|^2 ----------------
    logic signed [DW-1:0] q_brbr, q_bibi, q_brbi, q_arcr, q_aici, q_arci, q_aicr;
    logic signed [DW-1:0] dr_next, di_next;
    logic [DENW-1:0]      den_next;

    // products floor-shifted back to the fixed-point scale
    assign q_brbr = DW'(p_brbr_reg >>> F);
    assign q_bibi = DW'(p_bibi_reg >>> F);
    assign q_brbi = DW'(p_brbi_reg >>> F);
    assign q_arcr = DW'(p_arcr_reg >>> F);
    assign q_aici = DW'(p_aici_reg >>> F);
    assign q_arci = DW'(p_arci_reg >>> F);
    assign q_aicr = DW'(p_aicr_reg >>> F);

    assign dr_next  = q_brbr - q_bibi - ((q_arcr - q_aici) <<< 2);
    assign di_next  = (q_brbi <<< 1) - ((q_arci + q_aicr) <<< 2);
    assign den_next = $unsigned(p_arar_reg) + $unsigned(p_aiai_reg);

    logic signed [DW-1:0] dr_s2_reg, di_s2_reg;
    logic [DENW-1:0]      den_s2_reg;
    logic signed [W-1:0]  ar_s2_reg, ai_s2_reg, br_s2_reg, bi_s2_reg;
    logic                 lz_s2_reg, v2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            dr_s2_reg  <= dr_next;
            di_s2_reg  <= di_next;
            den_s2_reg <= den_next;
            ar_s2_reg  <= ar_s1_reg;
            ai_s2_reg  <= ai_s1_reg;
            br_s2_reg  <= br_s1_reg;
            bi_s2_reg  <= bi_s1_reg;
            lz_s2_reg  <= lz_s1_reg;
        end
    end

    // ---------------- stage 3: split partial products of dr^2, di^2 ----------------
    logic signed [HW-1:0] dr_hi, di_hi;
    logic signed [HB:0]   dr_lo, di_lo;
    assign dr_hi = $signed(dr_s2_reg[DW-1:HB]);
    assign di_hi = $signed(di_s2_reg[DW-1:HB]);
    assign dr_lo = $signed({1'b0, dr_s2_reg[HB-1:0]});
    assign di_lo = $signed({1'b0, di_s2_reg[HB-1:0]});

    logic signed [2*HW-1:0] dr_hh_reg, di_hh_reg;
    logic signed [DW:0]     dr_hl_reg, di_hl_reg;
    logic signed [2*HB+1:0] dr_ll_reg, di_ll_reg;
    logic signed [DW-1:0]   dr_s3_reg, di_s3_reg;
    logic [DENW-1:0]        den_s3_reg;
    logic signed [W-1:0]    ar_s3_reg, ai_s3_reg, br_s3_reg, bi_s3_reg;
    logic                   lz_s3_reg, v3_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            dr_hh_reg  <= dr_hi * dr_hi;
            dr_hl_reg  <= dr_hi * dr_lo;
            dr_ll_reg  <= dr_lo * dr_lo;
            di_hh_reg  <= di_hi * di_hi;
            di_hl_reg  <= di_hi * di_lo;
            di_ll_reg  <= di_lo * di_lo;
            dr_s3_reg  <= dr_s2_reg;
            di_s3_reg  <= di_s2_reg;
            den_s3_reg <= den_s2_reg;
            ar_s3_reg  <= ar_s2_reg;
            ai_s3_reg  <= ai_s2_reg;
            br_s3_reg  <= br_s2_reg;
            bi_s3_reg  <= bi_s2_reg;
            lz_s3_reg  <= lz_s2_reg;
        end
    end

    // ---------------- stage 4: |d|^2 ----------------
    logic signed [MW+1:0] msq_next;
    assign msq_next = sq_join(dr_hh_reg, dr_hl_reg, dr_ll_reg)
                    + sq_join(di_hh_reg, di_hl_reg, di_ll_reg);

    logic [MW-1:0] msq_s4_reg;
    sb1_t          sb1_s4_reg;
    logic          v4_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            msq_s4_reg <= msq_next[MW-1:0];
            sb1_s4_reg <= '{lz: lz_s3_reg, den: den_s3_reg, bi: bi_s3_reg, br: br_s3_reg,
                            ai: ai_s3_reg, ar: ar_s3_reg, di: di_s3_reg, dr: dr_s3_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ---------------- |d| = isqrt(|d|^2) ----------------
    logic          s1_valid;
    logic [DW-1:0] mm;
    sb1_t          sb1_out;
    pipe_ctl_t     ctl_mag;

    assign ctl_mag = '{ce: ce, valid: v4_reg};

    cqr_sqrt #(.IN_W(MW), .TAG_W($bits(sb1_t))) u_sqrt_mag (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_ctl   (ctl_mag),
        .in_rad   (msq_s4_reg),
        .in_tag   (sb1_s4_reg),
        .out_valid(s1_valid),
        .out_root (mm),
        .out_tag  (sb1_out)
    );

    // halves (|d| +/- re d) / 2, never negative
    logic signed [DW:0]  sum_hn, sum_hq;
    logic [S2IN-1:0]     rad_hn, rad_hq;
    logic                di_pos;
    assign sum_hn = $signed({1'b0, mm}) + (DW+1)'(sb1_out.dr);
    assign sum_hq = $signed({1'b0, mm}) - (DW+1)'(sb1_out.dr);
    assign rad_hn = {sum_hn[DW:1], {F{1'b0}}};
    assign rad_hq = {sum_hq[DW:1], {F{1'b0}}};
    assign di_pos = (sb1_out.di > 0);

    // ---------------- square root of d, real and imaginary ----------------
    logic          s2a_valid, s2b_valid;
    logic [SW-1:0] sre_root, sim_root;
    sb2_t          sb2_in;
    sb2_t          sb2_out;
    logic          di_pos_out;
    pipe_ctl_t     ctl_half;

    assign ctl_half = '{ce: ce, valid: s1_valid};
    assign sb2_in   = '{lz: sb1_out.lz, den: sb1_out.den, bi: sb1_out.bi, br: sb1_out.br,
                        ai: sb1_out.ai, ar: sb1_out.ar};

    cqr_sqrt #(.IN_W(S2IN), .TAG_W($bits(sb2_t))) u_sqrt_re (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_ctl   (ctl_half),
        .in_rad   (rad_hn),
        .in_tag   (sb2_in),
        .out_valid(s2a_valid),
        .out_root (sre_root),
        .out_tag  (sb2_out)
    );

    cqr_sqrt #(.IN_W(S2IN), .TAG_W(1)) u_sqrt_im (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_ctl   (ctl_half),
        .in_rad   (rad_hq),
        .in_tag   (di_pos),
        .out_valid(s2b_valid),
        .out_root (sim_root),
        .out_tag  (di_pos_out)
    );

    // ---------------- stage 6: signed root parts ----------------
    logic signed [XW-1:0] sre_ext, sim_ext;
    assign sre_ext = $signed({1'b0, sre_root});
    assign sim_ext = $signed({1'b0, sim_root});

    logic signed [XW-1:0] sre_s6_reg, sim_s6_reg;
    logic signed [W-1:0]  br_s6_reg, bi_s6_reg;
    sb3_t                 sb3_s6_reg;
    logic                 v6_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            sre_s6_reg <= sre_ext;
            sim_s6_reg <= di_pos_out ? sim_ext : -sim_ext;  // sign taken from im d, negative when im d is not positive
            br_s6_reg  <= sb2_out.br;
            bi_s6_reg  <= sb2_out.bi;
            sb3_s6_reg <= '{lz: sb2_out.lz, den: sb2_out.den, ai: sb2_out.ai, ar: sb2_out.ar};
        end
    end

    // ---------------- stage 7: -b + s and -b - s ----------------
    logic signed [XW-1:0] xp_s7_reg, yp_s7_reg, xm_s7_reg, ym_s7_reg;
    sb3_t                 sb3_s7_reg;
    logic                 v7_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            xp_s7_reg  <= sre_s6_reg - XW'(br_s6_reg);
            yp_s7_reg  <= sim_s6_reg - XW'(bi_s6_reg);
            xm_s7_reg  <= -XW'(br_s6_reg) - sre_s6_reg;
            ym_s7_reg  <= -XW'(bi_s6_reg) - sim_s6_reg;
            sb3_s7_reg <= sb3_s6_reg;
        end
    end

    // ---------------- stage 8: products with conj(a) ----------------
    logic signed [PW-1:0] xp_ar_reg, yp_ai_reg, yp_ar_reg, xp_ai_reg;
    logic signed [PW-1:0] xm_ar_reg, ym_ai_reg, ym_ar_reg, xm_ai_reg;
    logic                 lz_s8_reg, v8_reg;
    logic [DENW-1:0]      den_s8_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            xp_ar_reg  <= xp_s7_reg * sb3_s7_reg.ar;
            yp_ai_reg  <= yp_s7_reg * sb3_s7_reg.ai;
            yp_ar_reg  <= yp_s7_reg * sb3_s7_reg.ar;
            xp_ai_reg  <= xp_s7_reg * sb3_s7_reg.ai;
            xm_ar_reg  <= xm_s7_reg * sb3_s7_reg.ar;
            ym_ai_reg  <= ym_s7_reg * sb3_s7_reg.ai;
            ym_ar_reg  <= ym_s7_reg * sb3_s7_reg.ar;
            xm_ai_reg  <= xm_s7_reg * sb3_s7_reg.ai;
            lz_s8_reg  <= sb3_s7_reg.lz;
            den_s8_reg <= sb3_s7_reg.den;
        end
    end

    // ---------------- stage 9: numerators ----------------
    logic signed [NW-1:0] nrp_s9_reg, nip_s9_reg, nrm_s9_reg, nim_s9_reg;
    logic                 lz_s9_reg, v9_reg;
    logic [DENW-1:0]      den_s9_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            nrp_s9_reg <= NW'(xp_ar_reg) + NW'(yp_ai_reg);
            nip_s9_reg <= NW'(yp_ar_reg) - NW'(xp_ai_reg);
            nrm_s9_reg <= NW'(xm_ar_reg) + NW'(ym_ai_reg);
            nim_s9_reg <= NW'(ym_ar_reg) - NW'(xm_ai_reg);
            lz_s9_reg  <= lz_s8_reg;
            den_s9_reg <= den_s8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end else if (ce) begin
            v6_reg <= s2a_valid;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // ---------------- division by |a|^2, sign-magnitude ----------------
    logic           neg_rp, neg_ip, neg_rm, neg_im;
    logic [NW-1:0]  mag_rp, mag_ip, mag_rm, mag_im;
    assign neg_rp = nrp_s9_reg[NW-1];
    assign neg_ip = nip_s9_reg[NW-1];
    assign neg_rm = nrm_s9_reg[NW-1];
    assign neg_im = nim_s9_reg[NW-1];
    assign mag_rp = neg_rp ? $unsigned(-nrp_s9_reg) : $unsigned(nrp_s9_reg);
    assign mag_ip = neg_ip ? $unsigned(-nip_s9_reg) : $unsigned(nip_s9_reg);
    assign mag_rm = neg_rm ? $unsigned(-nrm_s9_reg) : $unsigned(nrm_s9_reg);
    assign mag_im = neg_im ? $unsigned(-nim_s9_reg) : $unsigned(nim_s9_reg);

    logic          dv0, dv1, dv2, dv3;
    logic [QN-1:0] q_rp, q_ip, q_rm, q_im;
    logic          lz_d, sg_rp, sg_ip, sg_rm, sg_im;
    pipe_ctl_t     ctl_div;

    assign ctl_div = '{ce: ce, valid: v9_reg};

    // scaling by 2^(F-1) folds in the factor 1/2 of 1/(2a)
    cqr_div #(.NUM_W(QN), .DEN_W(DENW), .TAG_W(2)) u_div_rp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_ctl   (ctl_div),
        .in_num   ({mag_rp, {(F-1){1'b0}}}),
        .in_den   (den_s9_reg),
        .in_tag   ({lz_s9_reg, neg_rp}),
        .out_valid(dv0),
        .out_quo  (q_rp),
        .out_tag  ({lz_d, sg_rp})
    );

    cqr_div #(.NUM_W(QN), .DEN_W(DENW), .TAG_W(1)) u_div_ip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_ctl   (ctl_div),
        .in_num   ({mag_ip, {(F-1){1'b0}}}),
        .in_den   (den_s9_reg),
        .in_tag   (neg_ip),
        .out_valid(dv1),
        .out_quo  (q_ip),
        .out_tag  (sg_ip)
    );

    cqr_div #(.NUM_W(QN), .DEN_W(DENW), .TAG_W(1)) u_div_rm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_ctl   (ctl_div),
        .in_num   ({mag_rm, {(F-1){1'b0}}}),
        .in_den   (den_s9_reg),
        .in_tag   (neg_rm),
        .out_valid(dv2),
        .out_quo  (q_rm),
        .out_tag  (sg_rm)
    );

    cqr_div #(.NUM_W(QN), .DEN_W(DENW), .TAG_W(1)) u_div_im (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_ctl   (ctl_div),
        .in_num   ({mag_im, {(F-1){1'b0}}}),
        .in_den   (den_s9_reg),
        .in_tag   (neg_im),
        .out_valid(dv3),
        .out_quo  (q_im),
        .out_tag  (sg_im)
    );

    // ---------------- output stage: clip, order, register ----------------
    logic [W:0]         c_rp, c_ip, c_rm, c_im;
    logic signed [W-1:0] pi_v, mi_v;
    logic               plus_first, sat_any;
    logic [4*W-1:0]     fields_next;

    assign c_rp = clip_q(q_rp, sg_rp);
    assign c_ip = clip_q(q_ip, sg_ip);
    assign c_rm = clip_q(q_rm, sg_rm);
    assign c_im = clip_q(q_im, sg_im);
    assign pi_v = $signed(c_ip[W-1:0]);
    assign mi_v = $signed(c_im[W-1:0]);
    // ties put the minus root first
    assign plus_first = (pi_v > mi_v);
    assign sat_any    = c_rp[W] | c_ip[W] | c_rm[W] | c_im[W];
    assign fields_next = lz_d ? '0 :
                         plus_first ? {c_im[W-1:0], c_rm[W-1:0], c_ip[W-1:0], c_rp[W-1:0]}
                                    : {c_ip[W-1:0], c_rp[W-1:0], c_im[W-1:0], c_rm[W-1:0]};

    logic [OUT_TD-1:0] m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= OUT_TD'(fields_next);
            m_tuser_reg <= {sat_any & ~lz_d, lz_d};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= dv0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    // parallel root units must stay in lockstep
    `CQR_ASSERT_EQ(a_sqrt_lockstep, s2a_valid, s2b_valid)
    // the four dividers must stay in lockstep
    `CQR_ASSERT_EQ(a_div_lockstep, {4{dv0}}, {dv0, dv1, dv2, dv3})
    // a zero leading coefficient reports all-zero roots and no clipping
    `CQR_ASSERT_IMP(a_lead_zero_clean, m_tvalid && m_tuser[0], (m_tdata == '0) && !m_tuser[1])

endmodule
